FILE: rtl/core/ttcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcw_pkg
// Shared types, codes and reset values of the text terminal cell writer.
// ----------------------------------------------------------------------------
package ttcw_pkg;

    localparam int MAX_ROWS_DEF    = 64;
    localparam int MAX_COLUMNS_DEF = 128;

    // Item opcodes.
    localparam logic [1:0] OP_PUT_ITEM = 2'd0;
    localparam logic [1:0] OP_PUT_CUR  = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;
    localparam logic [1:0] OP_READ     = 2'd3;

    // Control characters.
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_NUL       = 8'd0;

    // Configuration register indexes.
    localparam logic [1:0] CFG_COLUMNS    = 2'd0;
    localparam logic [1:0] CFG_ROWS       = 2'd1;
    localparam logic [1:0] CFG_FOREGROUND = 2'd2;
    localparam logic [1:0] CFG_BACKGROUND = 2'd3;

    localparam logic [7:0]  COLUMNS_RST    = 8'd120;
    localparam logic [6:0]  ROWS_RST       = 7'd49;
    localparam logic [23:0] FOREGROUND_RST = 24'hAAAAAA;
    localparam logic [23:0] BACKGROUND_RST = 24'h1A001A;

    localparam int CMD_QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        K_PUT,
        K_NEWLINE,
        K_BACKSPACE,
        K_CLEAR,
        K_READ
    } t_kind;

    // Classified command word handed from the front to the back.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  ch;
        logic [23:0] fg;
        logic [23:0] bg;
        logic [5:0]  rd_row;
        logic [6:0]  rd_col;
        logic        rd_hit;
    } t_cmd;

    // Effective (clamped) configuration seen by the back.
    typedef struct packed {
        logic [7:0]  cols;
        logic [6:0]  rows;
        logic [23:0] fg;
        logic [23:0] bg;
    } t_cfg;

    typedef enum logic [2:0] {
        S_BOOT,
        S_IDLE,
        S_PUT_NEXT,
        S_READ,
        S_SCROLL_COPY,
        S_SCROLL_DRAIN,
        S_SCROLL_ZERO,
        S_CLEAR
    } t_bstate;

endpackage

FILE: rtl/core/text_terminal_cell_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_cell_writer
// Character cell buffer of a text terminal with a cursor.
// ----------------------------------------------------------------------------
// Input words (valid/ready) carry one operation: put with item colors, put
// with current colors, clear, or read one cell. Each word gives exactly one
// result word (valid/ready) with the cursor after the operation, the read
// cell and a redraw flag. Configuration is a plain write port; the user must
// change registers only while the block is idle, which the block itself
// does not enforce. A word is queued in a two-entry command queue, so the
// front keeps taking words while the back works or its result waits.
// A scroll writes rows_in_use * MAX_COLUMNS cells and a clear writes
// rows_in_use * columns_in_use cells, both through the single write port
// of the cell store, one cell per cycle. After reset the store is swept to
// zero, MAX_ROWS * MAX_COLUMNS cells (8192 by default), with ready low. A
// receiver stall holds the result register; the back then stops before the
// next command and the queue fills.
// ----------------------------------------------------------------------------
module text_terminal_cell_writer #(
    parameter int MAX_ROWS    = ttcw_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLUMNS = ttcw_pkg::MAX_COLUMNS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_char_code,
    input  logic [23:0] i_item_foreground,
    input  logic [23:0] i_item_background,
    input  logic [5:0]  i_read_row,
    input  logic [6:0]  i_read_column,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_cursor_column,
    output logic [5:0]  o_cursor_row,
    output logic [7:0]  o_cell_char,
    output logic [23:0] o_cell_foreground,
    output logic [23:0] o_cell_background,
    output logic        o_redraw_all
);

    ttcw_pkg::t_cmd push_cmd;
    ttcw_pkg::t_cmd pop_cmd;
    ttcw_pkg::t_cfg cfg;
    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_empty;
    logic           boot_done;

    ttcw_front #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_opcode          (i_opcode),
        .i_char_code       (i_char_code),
        .i_item_foreground (i_item_foreground),
        .i_item_background (i_item_background),
        .i_read_row        (i_read_row),
        .i_read_column     (i_read_column),
        .i_queue_full      (queue_full),
        .i_boot_done       (boot_done),
        .o_push            (push),
        .o_cmd             (push_cmd),
        .o_cfg             (cfg)
    );

    ttcw_cmd_fifo u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (queue_full),
        .i_pop      (pop),
        .o_pop_cmd  (pop_cmd),
        .o_empty    (queue_empty)
    );

    ttcw_back #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_cmd             (pop_cmd),
        .i_cmd_empty       (queue_empty),
        .o_pop             (pop),
        .o_boot_done       (boot_done),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_cursor_column   (o_cursor_column),
        .o_cursor_row      (o_cursor_row),
        .o_cell_char       (o_cell_char),
        .o_cell_foreground (o_cell_foreground),
        .o_cell_background (o_cell_background),
        .o_redraw_all      (o_redraw_all)
    );

endmodule

FILE: rtl/core/ttcw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcw_front
// Holds the configuration registers and turns each accepted word into a
// classified command for the command queue.
// ----------------------------------------------------------------------------
module ttcw_front #(
    parameter int MAX_ROWS    = ttcw_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLUMNS = ttcw_pkg::MAX_COLUMNS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [23:0]      i_cfg_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_opcode,
    input  logic [7:0]       i_char_code,
    input  logic [23:0]      i_item_foreground,
    input  logic [23:0]      i_item_background,
    input  logic [5:0]       i_read_row,
    input  logic [6:0]       i_read_column,
    input  logic             i_queue_full,
    input  logic             i_boot_done,
    output logic             o_push,
    output ttcw_pkg::t_cmd   o_cmd,
    output ttcw_pkg::t_cfg   o_cfg
);

    localparam logic [8:0] ROW_LIM = 9'(MAX_ROWS);
    localparam logic [8:0] COL_LIM = 9'(MAX_COLUMNS);

    logic [7:0]  r_cols;
    logic [6:0]  r_rows;
    logic [23:0] r_fg;
    logic [23:0] r_bg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= ttcw_pkg::COLUMNS_RST;
            r_rows <= ttcw_pkg::ROWS_RST;
            r_fg   <= ttcw_pkg::FOREGROUND_RST;
            r_bg   <= ttcw_pkg::BACKGROUND_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ttcw_pkg::CFG_COLUMNS:    r_cols <= i_cfg_data[7:0];
                ttcw_pkg::CFG_ROWS:       r_rows <= i_cfg_data[6:0];
                ttcw_pkg::CFG_FOREGROUND: r_fg   <= i_cfg_data;
                ttcw_pkg::CFG_BACKGROUND: r_bg   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.fg = r_fg;
        o_cfg.bg = r_bg;
        if (r_cols < 8'd2) begin
            o_cfg.cols = 8'd2;
        end else if (9'(r_cols) > COL_LIM) begin
            o_cfg.cols = 8'(MAX_COLUMNS);
        end else begin
            o_cfg.cols = r_cols;
        end
        if (r_rows == 7'd0) begin
            o_cfg.rows = 7'd1;
        end else if (9'(r_rows) > ROW_LIM) begin
            o_cfg.rows = 7'(MAX_ROWS);
        end else begin
            o_cfg.rows = r_rows;
        end
    end

    assign o_ready = i_boot_done && !i_queue_full;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        o_cmd.ch     = i_char_code;
        o_cmd.fg     = i_item_foreground;
        o_cmd.bg     = i_item_background;
        o_cmd.rd_row = i_read_row;
        o_cmd.rd_col = i_read_column;
        o_cmd.rd_hit = (9'(i_read_row) < ROW_LIM) && (9'(i_read_column) < COL_LIM);
        o_cmd.kind   = ttcw_pkg::K_PUT;
        unique case (i_opcode)
            ttcw_pkg::OP_PUT_ITEM, ttcw_pkg::OP_PUT_CUR: begin
                if (i_opcode == ttcw_pkg::OP_PUT_CUR) begin
                    o_cmd.fg = r_fg;
                    o_cmd.bg = r_bg;
                end
                if (i_char_code == ttcw_pkg::CH_NEWLINE) begin
                    o_cmd.kind = ttcw_pkg::K_NEWLINE;
                end else if (i_char_code == ttcw_pkg::CH_BACKSPACE) begin
                    o_cmd.kind = ttcw_pkg::K_BACKSPACE;
                end else begin
                    o_cmd.kind = ttcw_pkg::K_PUT;
                end
            end
            ttcw_pkg::OP_CLEAR: o_cmd.kind = ttcw_pkg::K_CLEAR;
            ttcw_pkg::OP_READ:  o_cmd.kind = ttcw_pkg::K_READ;
            default:            o_cmd.kind = ttcw_pkg::K_PUT;
        endcase
    end

endmodule

FILE: rtl/core/ttcw_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcw_cmd_fifo
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module ttcw_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ttcw_pkg::t_cmd i_push_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output ttcw_pkg::t_cmd o_pop_cmd,
    output logic           o_empty
);

    ttcw_pkg::t_cmd r_slot [ttcw_pkg::CMD_QUEUE_DEPTH];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    assign o_full    = (r_count == 2'(ttcw_pkg::CMD_QUEUE_DEPTH));
    assign o_empty   = (r_count == 2'd0);
    assign o_pop_cmd = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

FILE: rtl/core/ttcw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcw_back
// Executes commands against the cell store and the cursor, and holds the
// result word until the receiver takes it.
// ----------------------------------------------------------------------------
module ttcw_back #(
    parameter int MAX_ROWS    = ttcw_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLUMNS = ttcw_pkg::MAX_COLUMNS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ttcw_pkg::t_cfg i_cfg,
    input  ttcw_pkg::t_cmd i_cmd,
    input  logic           i_cmd_empty,
    output logic           o_pop,
    output logic           o_boot_done,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [6:0]     o_cursor_column,
    output logic [5:0]     o_cursor_row,
    output logic [7:0]     o_cell_char,
    output logic [23:0]    o_cell_foreground,
    output logic [23:0]    o_cell_background,
    output logic           o_redraw_all
);

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;

    localparam logic [8:0]    ROW_LIM = 9'(MAX_ROWS);
    localparam logic [8:0]    COL_LIM = 9'(MAX_COLUMNS);
    localparam logic [CW-1:0] X_LAST  = CW'(MAX_COLUMNS - 1);
    localparam logic [7:0]    Y_LAST  = 8'(MAX_ROWS - 1);

    function automatic logic [AW-1:0] f_addr(input logic [7:0] row, input logic [CW-1:0] col);
        return {row[RW-1:0], col};
    endfunction

    function automatic logic f_in_store(input logic [7:0] row, input logic [8:0] col);
        return (9'(row) < ROW_LIM) && (col < COL_LIM);
    endfunction

    // Cell store: character and color pair kept apart so the character of a
    // neighbor cell can be cleared without touching its colors.
    logic [7:0]  r_ch_ram    [DEPTH];
    logic [47:0] r_color_ram [DEPTH];
    logic [7:0]  r_rd_ch;
    logic [47:0] r_rd_color;

    ttcw_pkg::t_bstate r_state, n_state;
    logic [6:0]    r_col, n_col;
    logic [5:0]    r_row, n_row;
    logic [7:0]    r_y, n_y;
    logic [CW-1:0] r_x, n_x;
    logic [7:0]    r_wcol, n_wcol;
    logic          r_hit, n_hit;
    logic          r_wb_valid, n_wb_valid;
    logic [AW-1:0] r_wb_addr, n_wb_addr;

    logic          r_out_valid;
    logic [6:0]    r_out_col;
    logic [5:0]    r_out_row;
    logic [7:0]    r_out_ch;
    logic [23:0]   r_out_fg;
    logic [23:0]   r_out_bg;
    logic          r_out_redraw;

    logic          ch_we;
    logic          color_we;
    logic [AW-1:0] wr_addr;
    logic [7:0]    ch_d;
    logic [47:0]   color_d;
    logic [AW-1:0] rd_addr;
    logic          load;
    logic [7:0]    ld_ch;
    logic [47:0]   ld_color;
    logic          ld_redraw;
    logic          out_free;

    assign out_free    = !r_out_valid || i_ready;
    assign o_boot_done = (r_state != ttcw_pkg::S_BOOT);

    always_ff @(posedge i_clk) begin
        if (ch_we) begin
            r_ch_ram[wr_addr] <= ch_d;
        end
        if (color_we) begin
            r_color_ram[wr_addr] <= color_d;
        end
        r_rd_ch    <= r_ch_ram[rd_addr];
        r_rd_color <= r_color_ram[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ttcw_pkg::S_BOOT;
            r_col      <= '0;
            r_row      <= '0;
            r_y        <= '0;
            r_x        <= '0;
            r_wb_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_col      <= n_col;
            r_row      <= n_row;
            r_y        <= n_y;
            r_x        <= n_x;
            r_wb_valid <= n_wb_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wcol    <= n_wcol;
        r_hit     <= n_hit;
        r_wb_addr <= n_wb_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_col    <= n_col;
            r_out_row    <= n_row;
            r_out_ch     <= ld_ch;
            r_out_fg     <= ld_color[47:24];
            r_out_bg     <= ld_color[23:0];
            r_out_redraw <= ld_redraw;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_row      = r_row;
        n_y        = r_y;
        n_x        = r_x;
        n_wcol     = r_wcol;
        n_hit      = r_hit;
        n_wb_valid = 1'b0;
        n_wb_addr  = r_wb_addr;
        ch_we      = 1'b0;
        color_we   = 1'b0;
        wr_addr    = r_wb_addr;
        ch_d       = r_rd_ch;
        color_d    = r_rd_color;
        rd_addr    = f_addr(8'(i_cmd.rd_row), CW'(i_cmd.rd_col));
        o_pop      = 1'b0;
        load       = 1'b0;
        ld_ch      = ttcw_pkg::CH_NUL;
        ld_color   = '0;
        ld_redraw  = 1'b0;

        // Write-back half of the scroll copy pipeline.
        if (r_wb_valid) begin
            ch_we    = 1'b1;
            color_we = 1'b1;
        end

        unique case (r_state)
            ttcw_pkg::S_BOOT: begin
                ch_we    = 1'b1;
                color_we = 1'b1;
                wr_addr  = f_addr(r_y, r_x);
                ch_d     = ttcw_pkg::CH_NUL;
                color_d  = '0;
                if (r_x == X_LAST) begin
                    n_x = '0;
                    n_y = r_y + 8'd1;
                    if (r_y == Y_LAST) begin
                        n_state = ttcw_pkg::S_IDLE;
                    end
                end else begin
                    n_x = r_x + CW'(1);
                end
            end
            ttcw_pkg::S_IDLE: begin
                if (!i_cmd_empty && out_free) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.kind)
                        ttcw_pkg::K_PUT: begin
                            if (8'(r_col) + 8'd1 < i_cfg.cols) begin
                                if (f_in_store(8'(r_row), 9'(r_col))) begin
                                    ch_we    = 1'b1;
                                    color_we = 1'b1;
                                    wr_addr  = f_addr(8'(r_row), CW'(r_col));
                                    ch_d     = i_cmd.ch;
                                    color_d  = {i_cmd.fg, i_cmd.bg};
                                end
                                n_col   = r_col + 7'd1;
                                n_wcol  = 8'(r_col) + 8'd1;
                                n_state = ttcw_pkg::S_PUT_NEXT;
                            end else begin
                                load = 1'b1;
                            end
                        end
                        ttcw_pkg::K_NEWLINE: begin
                            n_col = '0;
                            if (8'(r_row) + 8'd1 >= 8'(i_cfg.rows)) begin
                                n_row = 6'(i_cfg.rows - 7'd1);
                                n_x   = '0;
                                n_y   = 8'd1;
                                if (i_cfg.rows > 7'd1) begin
                                    n_state = ttcw_pkg::S_SCROLL_COPY;
                                end else begin
                                    n_state = ttcw_pkg::S_SCROLL_ZERO;
                                end
                            end else begin
                                n_row = r_row + 6'd1;
                                load  = 1'b1;
                            end
                        end
                        ttcw_pkg::K_BACKSPACE: begin
                            if (r_col != 7'd0) begin
                                n_col = r_col - 7'd1;
                                if (f_in_store(8'(r_row), 9'(n_col))) begin
                                    ch_we   = 1'b1;
                                    wr_addr = f_addr(8'(r_row), CW'(n_col));
                                    ch_d    = ttcw_pkg::CH_NUL;
                                end
                            end
                            load = 1'b1;
                        end
                        ttcw_pkg::K_CLEAR: begin
                            n_col   = '0;
                            n_row   = '0;
                            n_y     = '0;
                            n_x     = '0;
                            n_state = ttcw_pkg::S_CLEAR;
                        end
                        ttcw_pkg::K_READ: begin
                            n_hit   = i_cmd.rd_hit;
                            n_state = ttcw_pkg::S_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ttcw_pkg::S_PUT_NEXT: begin
                // The cell after the new character loses its character only.
                if (f_in_store(8'(r_row), 9'(r_wcol))) begin
                    ch_we   = 1'b1;
                    wr_addr = f_addr(8'(r_row), CW'(r_wcol));
                    ch_d    = ttcw_pkg::CH_NUL;
                end
                load    = 1'b1;
                n_state = ttcw_pkg::S_IDLE;
            end
            ttcw_pkg::S_READ: begin
                if (r_hit) begin
                    ld_ch    = r_rd_ch;
                    ld_color = r_rd_color;
                end
                load    = 1'b1;
                n_state = ttcw_pkg::S_IDLE;
            end
            ttcw_pkg::S_SCROLL_COPY: begin
                // Read row y now, write it to row y-1 in the next cycle.
                rd_addr    = f_addr(r_y, r_x);
                n_wb_valid = 1'b1;
                n_wb_addr  = f_addr(r_y - 8'd1, r_x);
                if (r_x == X_LAST) begin
                    n_x = '0;
                    if (r_y == 8'(i_cfg.rows) - 8'd1) begin
                        n_state = ttcw_pkg::S_SCROLL_DRAIN;
                    end else begin
                        n_y = r_y + 8'd1;
                    end
                end else begin
                    n_x = r_x + CW'(1);
                end
            end
            ttcw_pkg::S_SCROLL_DRAIN: begin
                n_x     = '0;
                n_state = ttcw_pkg::S_SCROLL_ZERO;
            end
            ttcw_pkg::S_SCROLL_ZERO: begin
                ch_we    = 1'b1;
                color_we = 1'b1;
                wr_addr  = f_addr(8'(i_cfg.rows) - 8'd1, r_x);
                ch_d     = ttcw_pkg::CH_NUL;
                color_d  = '0;
                if (r_x == X_LAST) begin
                    ld_redraw = 1'b1;
                    load      = 1'b1;
                    n_state   = ttcw_pkg::S_IDLE;
                end else begin
                    n_x = r_x + CW'(1);
                end
            end
            ttcw_pkg::S_CLEAR: begin
                ch_we    = 1'b1;
                color_we = 1'b1;
                wr_addr  = f_addr(r_y, r_x);
                ch_d     = ttcw_pkg::CH_NUL;
                color_d  = {i_cfg.fg, i_cfg.bg};
                if (8'(r_x) == i_cfg.cols - 8'd1) begin
                    n_x = '0;
                    if (r_y == 8'(i_cfg.rows) - 8'd1) begin
                        ld_redraw = 1'b1;
                        load      = 1'b1;
                        n_state   = ttcw_pkg::S_IDLE;
                    end else begin
                        n_y = r_y + 8'd1;
                    end
                end else begin
                    n_x = r_x + CW'(1);
                end
            end
            default: n_state = ttcw_pkg::S_IDLE;
        endcase
    end

    assign o_valid           = r_out_valid;
    assign o_cursor_column   = r_out_col;
    assign o_cursor_row      = r_out_row;
    assign o_cell_char       = r_out_ch;
    assign o_cell_foreground = r_out_fg;
    assign o_cell_background = r_out_bg;
    assign o_redraw_all      = r_out_redraw;

endmodule

FILE: rtl/core/ttcw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcw_checker
// Port-level checks of the text terminal cell writer, bound to the top level.
// ----------------------------------------------------------------------------
module ttcw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [6:0]  o_cursor_column,
    input logic [5:0]  o_cursor_row,
    input logic [7:0]  o_cell_char,
    input logic [23:0] o_cell_foreground,
    input logic [23:0] o_cell_background,
    input logic        o_redraw_all
);

    // The store sweep after reset keeps the input side closed.
    a_ready_low_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("ready raised right after reset");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_cursor_column) &&
            $stable(o_cursor_row) && $stable(o_cell_char) && $stable(o_redraw_all))
        else $error("stalled result word changed");

    // Scroll and clear both leave the cursor in column zero.
    a_redraw_homes_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_redraw_all |-> o_cursor_column == 7'd0)
        else $error("redraw result with cursor off column zero");

    // Only a read returns cell contents, and a read never redraws.
    a_redraw_no_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_redraw_all |-> o_cell_char == 8'd0 &&
            o_cell_foreground == 24'd0 && o_cell_background == 24'd0)
        else $error("redraw result carries cell data");

endmodule

bind text_terminal_cell_writer ttcw_checker u_checker (.*);

FILE: dv/text_terminal_cell_writer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_cell_writer_test
// Self-checking bench for the text terminal cell writer.
// ----------------------------------------------------------------------------
// A shadow copy of the cell store and cursor is updated for every accepted
// input word. It predicts the cursor, read cell and redraw flag of each result
// word, and these are compared field by field in arrival order. Directed tests
// cover the reset setup, the tiny and the full-size screen, a cursor left
// outside a shrunken screen and a long receiver stall. Random phases with
// random screen sizes follow. Both sides insert random idle gaps.
// ----------------------------------------------------------------------------
module text_terminal_cell_writer_test;

    localparam int CLK_PERIOD   = 20;
    localparam int STORE_ROWS   = ttcw_pkg::MAX_ROWS_DEF;
    localparam int STORE_COLS   = ttcw_pkg::MAX_COLUMNS_DEF;
    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [6:0]  col;
        logic [5:0]  row;
        logic [7:0]  ch;
        logic [23:0] fg;
        logic [23:0] bg;
        logic        redraw;
    } t_cell_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [23:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_opcode;
    logic [7:0]  i_char_code;
    logic [23:0] i_item_foreground;
    logic [23:0] i_item_background;
    logic [5:0]  i_read_row;
    logic [6:0]  i_read_column;
    logic        o_valid;
    logic        i_ready;
    logic [6:0]  o_cursor_column;
    logic [5:0]  o_cursor_row;
    logic [7:0]  o_cell_char;
    logic [23:0] o_cell_foreground;
    logic [23:0] o_cell_background;
    logic        o_redraw_all;

    // Shadow of the block's state and configuration.
    logic [7:0]  shadow_ch [STORE_ROWS][STORE_COLS];
    logic [23:0] shadow_fg [STORE_ROWS][STORE_COLS];
    logic [23:0] shadow_bg [STORE_ROWS][STORE_COLS];
    logic [6:0]  shadow_col;
    logic [5:0]  shadow_row;
    logic [7:0]  cfg_cols;
    logic [6:0]  cfg_rows;
    logic [23:0] cfg_fg;
    logic [23:0] cfg_bg;

    t_cell_result cursor_cell_queue[$];
    int  err_count   = 0;
    bit  tx_idle_on  = 1'b1;
    bit  rx_idle_on  = 1'b1;
    int  hold_len    = 0;

    text_terminal_cell_writer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_opcode         (i_opcode),
        .i_char_code      (i_char_code),
        .i_item_foreground(i_item_foreground),
        .i_item_background(i_item_background),
        .i_read_row       (i_read_row),
        .i_read_column    (i_read_column),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_cursor_column  (o_cursor_column),
        .o_cursor_row     (o_cursor_row),
        .o_cell_char      (o_cell_char),
        .o_cell_foreground(o_cell_foreground),
        .o_cell_background(o_cell_background),
        .o_redraw_all     (o_redraw_all)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("text_terminal_cell_writer_test: errors");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 60) begin
            return 0;
        end else if (r < 93) begin
            return int'($urandom_range(1, 3));
        end
        return int'($urandom_range(10, 40));
    endfunction

    function automatic logic [7:0] pick_printable();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == ttcw_pkg::CH_NEWLINE || c == ttcw_pkg::CH_BACKSPACE);
        return c;
    endfunction

    function automatic logic [1:0] pick_put_op();
        return ($urandom_range(0, 1) == 0) ? ttcw_pkg::OP_PUT_ITEM : ttcw_pkg::OP_PUT_CUR;
    endfunction

    // Applies one word to the shadow state and queues the result it owes.
    task automatic mirror_terminal_op(input logic [1:0] op, input logic [7:0] ch,
                                      input logic [23:0] fg, input logic [23:0] bg,
                                      input logic [5:0] rr, input logic [6:0] rc);
        t_cell_result res;
        int ncols, nrows, row, col, y, x;
        logic [23:0] pfg, pbg;
        res   = '0;
        ncols = (cfg_cols < 2) ? 2 : (cfg_cols > STORE_COLS) ? STORE_COLS : int'(cfg_cols);
        nrows = (cfg_rows < 1) ? 1 : (cfg_rows > STORE_ROWS) ? STORE_ROWS : int'(cfg_rows);
        row   = int'(shadow_row);
        col   = int'(shadow_col);
        pfg   = (op == ttcw_pkg::OP_PUT_ITEM) ? fg : cfg_fg;
        pbg   = (op == ttcw_pkg::OP_PUT_ITEM) ? bg : cfg_bg;
        // The cursor field widths keep every touched cell inside the store.
        case (op)
            ttcw_pkg::OP_PUT_ITEM, ttcw_pkg::OP_PUT_CUR: begin
                if (ch == ttcw_pkg::CH_NEWLINE) begin
                    shadow_col = '0;
                    if (row + 1 >= nrows) begin
                        for (y = 1; y < nrows; y++) begin
                            for (x = 0; x < STORE_COLS; x++) begin
                                shadow_ch[y - 1][x] = shadow_ch[y][x];
                                shadow_fg[y - 1][x] = shadow_fg[y][x];
                                shadow_bg[y - 1][x] = shadow_bg[y][x];
                            end
                        end
                        for (x = 0; x < STORE_COLS; x++) begin
                            shadow_ch[nrows - 1][x] = ttcw_pkg::CH_NUL;
                            shadow_fg[nrows - 1][x] = '0;
                            shadow_bg[nrows - 1][x] = '0;
                        end
                        shadow_row = 6'(nrows - 1);
                        res.redraw = 1'b1;
                    end else begin
                        shadow_row = 6'(row + 1);
                    end
                end else if (ch == ttcw_pkg::CH_BACKSPACE) begin
                    if (col > 0) begin
                        shadow_col = 7'(col - 1);
                        shadow_ch[row][col - 1] = ttcw_pkg::CH_NUL;
                    end
                end else if (col + 1 < ncols) begin
                    shadow_ch[row][col] = ch;
                    shadow_fg[row][col] = pfg;
                    shadow_bg[row][col] = pbg;
                    shadow_col = 7'(col + 1);
                    shadow_ch[row][col + 1] = ttcw_pkg::CH_NUL;
                end
            end
            ttcw_pkg::OP_CLEAR: begin
                for (y = 0; y < nrows; y++) begin
                    for (x = 0; x < ncols; x++) begin
                        shadow_ch[y][x] = ttcw_pkg::CH_NUL;
                        shadow_fg[y][x] = cfg_fg;
                        shadow_bg[y][x] = cfg_bg;
                    end
                end
                shadow_col = '0;
                shadow_row = '0;
                res.redraw = 1'b1;
            end
            default: begin
                res.ch = shadow_ch[rr][rc];
                res.fg = shadow_fg[rr][rc];
                res.bg = shadow_bg[rr][rc];
            end
        endcase
        res.col = shadow_col;
        res.row = shadow_row;
        cursor_cell_queue.push_back(res);
    endtask

    // Offers one word and returns at the edge where it is taken.
    task automatic send_word(input logic [1:0] op, input logic [7:0] ch,
                             input logic [23:0] fg, input logic [23:0] bg,
                             input logic [5:0] rr, input logic [6:0] rc);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_opcode          <= op;
        i_char_code       <= ch;
        i_item_foreground <= fg;
        i_item_background <= bg;
        i_read_row        <= rr;
        i_read_column     <= rc;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        mirror_terminal_op(op, ch, fg, bg, rr, rc);
    endtask

    task automatic put_char(input logic [1:0] op, input logic [7:0] ch);
        send_word(op, ch, 24'($urandom()), 24'($urandom()), 6'($urandom()),
                  7'($urandom()));
    endtask

    task automatic read_cell(input logic [5:0] rr, input logic [6:0] rc);
        send_word(ttcw_pkg::OP_READ, 8'($urandom()), 24'($urandom()), 24'($urandom()),
                  rr, rc);
    endtask

    task automatic clear_screen();
        send_word(ttcw_pkg::OP_CLEAR, 8'($urandom()), 24'($urandom()), 24'($urandom()),
                  6'($urandom()), 7'($urandom()));
    endtask

    // Stops offering words and waits until every owed result has arrived.
    task automatic settle();
        i_valid <= 1'b0;
        while (cursor_cell_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [7:0] cols, input logic [6:0] rows,
                                input logic [23:0] fg, input logic [23:0] bg);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= ttcw_pkg::CFG_COLUMNS;
        i_cfg_data  <= {16'd0, cols};
        @(posedge i_clk);
        i_cfg_index <= ttcw_pkg::CFG_ROWS;
        i_cfg_data  <= {17'd0, rows};
        @(posedge i_clk);
        i_cfg_index <= ttcw_pkg::CFG_FOREGROUND;
        i_cfg_data  <= fg;
        @(posedge i_clk);
        i_cfg_index <= ttcw_pkg::CFG_BACKGROUND;
        i_cfg_data  <= bg;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_cols = cols;
        cfg_rows = rows;
        cfg_fg   = fg;
        cfg_bg   = bg;
    endtask

    task automatic test_reset_setup();
        read_cell(6'd0, 7'd0);
        send_word(ttcw_pkg::OP_PUT_ITEM, 8'hFF, 24'hFFFFFF, 24'h000000, 6'd63, 7'd127);
        send_word(ttcw_pkg::OP_PUT_ITEM, 8'h01, 24'h000000, 24'hFFFFFF, 6'd0, 7'd0);
        put_char(ttcw_pkg::OP_PUT_CUR, ttcw_pkg::CH_NUL);
        read_cell(6'd0, 7'd0);
        read_cell(6'd0, 7'd2);
        put_char(ttcw_pkg::OP_PUT_CUR, ttcw_pkg::CH_BACKSPACE);
        read_cell(6'd0, 7'd2);
        put_char(ttcw_pkg::OP_PUT_ITEM, ttcw_pkg::CH_BACKSPACE);
        put_char(ttcw_pkg::OP_PUT_CUR, ttcw_pkg::CH_BACKSPACE);
        put_char(ttcw_pkg::OP_PUT_CUR, ttcw_pkg::CH_BACKSPACE);
        put_char(ttcw_pkg::OP_PUT_ITEM, ttcw_pkg::CH_NEWLINE);
        send_word(ttcw_pkg::OP_CLEAR, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 6'd63, 7'd127);
        read_cell(6'd0, 7'd0);
        read_cell(6'd48, 7'd119);
        read_cell(6'd63, 7'd127);
        settle();
    endtask

    // Raw sizes below the legal range clamp to a two-column, one-row screen.
    task automatic test_tiny_screen();
        write_config(8'd0, 7'd0, 24'($urandom()), 24'($urandom()));
        send_word(ttcw_pkg::OP_PUT_ITEM, 8'h41, 24'h000000, 24'hFFFFFF, 6'd0, 7'd0);
        put_char(ttcw_pkg::OP_PUT_CUR, 8'h42);
        read_cell(6'd0, 7'd0);
        read_cell(6'd0, 7'd1);
        put_char(ttcw_pkg::OP_PUT_CUR, ttcw_pkg::CH_BACKSPACE);
        put_char(ttcw_pkg::OP_PUT_CUR, ttcw_pkg::CH_BACKSPACE);
        put_char(ttcw_pkg::OP_PUT_ITEM, 8'h43);
        put_char(ttcw_pkg::OP_PUT_ITEM, ttcw_pkg::CH_NEWLINE);
        read_cell(6'd0, 7'd0);
        settle();
        write_config(8'd2, 7'd1, 24'h000000, 24'hFFFFFF);
        put_char(ttcw_pkg::OP_PUT_CUR, pick_printable());
        put_char(ttcw_pkg::OP_PUT_CUR, pick_printable());
        clear_screen();
        read_cell(6'd0, 7'd1);
        read_cell(6'd0, 7'd2);
        put_char(ttcw_pkg::OP_PUT_CUR, ttcw_pkg::CH_NEWLINE);
        settle();
    endtask

    // Full-size screen: fill one whole row, then scroll the whole store.
    task automatic test_full_screen();
        int i;
        write_config(8'd255, 7'd127, 24'($urandom()), 24'($urandom()));
        clear_screen();
        for (i = 0; i < STORE_COLS; i++) begin
            put_char(pick_put_op(), pick_printable());
        end
        read_cell(6'd0, 7'd126);
        read_cell(6'd0, 7'd127);
        for (i = 0; i < STORE_ROWS; i++) begin
            put_char(pick_put_op(), ttcw_pkg::CH_NEWLINE);
        end
        read_cell(6'd63, 7'd5);
        read_cell(6'd62, 7'd126);
        settle();
    endtask

    // The cursor is left outside the screen when the screen shrinks.
    task automatic test_shrink();
        int i;
        write_config(8'd40, 7'd20, 24'($urandom()), 24'($urandom()));
        clear_screen();
        for (i = 0; i < 10; i++) put_char(ttcw_pkg::OP_PUT_CUR, ttcw_pkg::CH_NEWLINE);
        for (i = 0; i < 30; i++) put_char(ttcw_pkg::OP_PUT_ITEM, pick_printable());
        settle();
        write_config(8'd10, 7'd4, 24'($urandom()), 24'($urandom()));
        put_char(ttcw_pkg::OP_PUT_CUR, pick_printable());
        put_char(ttcw_pkg::OP_PUT_ITEM, ttcw_pkg::CH_BACKSPACE);
        read_cell(6'd10, 7'd29);
        read_cell(6'd10, 7'd28);
        put_char(ttcw_pkg::OP_PUT_ITEM, pick_printable());
        put_char(ttcw_pkg::OP_PUT_CUR, ttcw_pkg::CH_NEWLINE);
        read_cell(6'd10, 7'd5);
        read_cell(6'd3, 7'd0);
        clear_screen();
        read_cell(6'd3, 7'd9);
        read_cell(6'd3, 7'd10);
        read_cell(6'd10, 7'd5);
        settle();
    endtask

    // The receiver holds off long enough for the block to stall its input.
    task automatic test_back_pressure();
        int i;
        tx_idle_on = 1'b0;
        hold_len   = 300;
        for (i = 0; i < 12; i++) begin
            if (i % 3 == 2) begin
                read_cell(shadow_row, shadow_col);
            end else begin
                put_char(pick_put_op(), pick_printable());
            end
        end
        tx_idle_on = 1'b1;
        settle();
    endtask

    task automatic test_random_text();
        int phase, i, r;
        logic [7:0] cols;
        logic [6:0] rows;
        for (phase = 0; phase < 4; phase++) begin
            case ($urandom_range(0, 5))
                0: cols = 8'd2;
                1: cols = 8'($urandom_range(3, 8));
                2: cols = 8'($urandom_range(9, 40));
                3: cols = 8'($urandom_range(41, 128));
                4: cols = 8'($urandom_range(0, 1));
                default: cols = 8'($urandom_range(129, 255));
            endcase
            case ($urandom_range(0, 4))
                0: rows = 7'd1;
                1: rows = 7'($urandom_range(2, 4));
                2: rows = 7'($urandom_range(5, 12));
                3: rows = 7'd0;
                default: rows = 7'($urandom_range(13, 127));
            endcase
            write_config(cols, rows, 24'($urandom()), 24'($urandom()));
            // The first phase runs with no idle cycles on either side.
            tx_idle_on = (phase != 0);
            rx_idle_on = (phase != 0);
            for (i = 0; i < 45; i++) begin
                r = int'($urandom_range(0, 99));
                if (r < 50) begin
                    put_char(pick_put_op(), pick_printable());
                end else if (r < 62) begin
                    put_char(pick_put_op(), ttcw_pkg::CH_NEWLINE);
                end else if (r < 72) begin
                    put_char(pick_put_op(), ttcw_pkg::CH_BACKSPACE);
                end else if (r < 75) begin
                    clear_screen();
                end else if (r < 88) begin
                    read_cell(shadow_row, 7'($urandom_range(0, shadow_col)));
                end else begin
                    read_cell(6'($urandom()), 7'($urandom()));
                end
            end
            settle();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        int x, y;
        for (y = 0; y < STORE_ROWS; y++) begin
            for (x = 0; x < STORE_COLS; x++) begin
                shadow_ch[y][x] = '0;
                shadow_fg[y][x] = '0;
                shadow_bg[y][x] = '0;
            end
        end
        shadow_col = '0;
        shadow_row = '0;
        cfg_cols   = ttcw_pkg::COLUMNS_RST;
        cfg_rows   = ttcw_pkg::ROWS_RST;
        cfg_fg     = ttcw_pkg::FOREGROUND_RST;
        cfg_bg     = ttcw_pkg::BACKGROUND_RST;

        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_index       <= ttcw_pkg::CFG_COLUMNS;
        i_cfg_data        <= '0;
        i_valid           <= 1'b0;
        i_opcode          <= ttcw_pkg::OP_READ;
        i_char_code       <= '0;
        i_item_foreground <= '0;
        i_item_background <= '0;
        i_read_row        <= '0;
        i_read_column     <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_setup();
        test_tiny_screen();
        test_full_screen();
        test_shrink();
        test_back_pressure();
        test_random_text();

        settle();
        repeat (40) @(posedge i_clk);
        if (err_count == 0) begin
            $display("text_terminal_cell_writer_test: clean");
        end else begin
            $display("text_terminal_cell_writer_test: errors");
        end
        $finish;
    end

    // Result side: random stalls, plus one long hold on request.
    initial begin
        int stall_left;
        int n;
        stall_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_len > 0) begin
                n        = hold_len;
                hold_len = 0;
                i_ready <= 1'b0;
                repeat (n - 1) @(posedge i_clk);
            end else if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
                if (rx_idle_on && $urandom_range(0, 7) == 0) stall_left = pick_gap();
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_cell_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (cursor_cell_queue.size() == 0) begin
                $display("%0t: result word with nothing owed, expected none, actual col %0h row %0h",
                         $time, o_cursor_column, o_cursor_row);
                err_count++;
            end else begin
                want = cursor_cell_queue.pop_front();
                check_field("cursor_column", 32'(want.col), 32'(o_cursor_column));
                check_field("cursor_row", 32'(want.row), 32'(o_cursor_row));
                check_field("cell_char", 32'(want.ch), 32'(o_cell_char));
                check_field("cell_foreground", 32'(want.fg), 32'(o_cell_foreground));
                check_field("cell_background", 32'(want.bg), 32'(o_cell_background));
                check_field("redraw_all", 32'(want.redraw), 32'(o_redraw_all));
            end
        end
    end

endmodule
